/* rtl/assert_macros.svh */
// assertion macros shared by the preview converter rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PPCA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppca assertion failed");

// next-cycle implication, disabled while reset is low
`define PPCA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppca assertion failed");

`endif

/* rtl/ppca_pkg.sv */
// shared types and constants for the preview pixel converter
// no dependencies; used by the channel interfaces, the blend unit and the top level
package ppca_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned PROD_W     = 2 * PIX_W;
  localparam int unsigned SUM3_W     = PIX_W + 2;

  // reset levels of the checkerboard
  localparam logic [PIX_W-1:0] CHECKER_DARK_RST  = 8'hA0;
  localparam logic [PIX_W-1:0] CHECKER_LIGHT_RST = 8'hE0;
  localparam logic [PIX_W-1:0] ALPHA_MAX         = 8'hFF;

  // divide by three on sums up to 765: (s * 683) >> 11 is exact there
  localparam int unsigned      DIV3_SHIFT = 11;
  localparam logic [SUM3_W-1:0] DIV3_MUL  = 10'd683;

  // source pixel formats
  typedef enum logic [1:0] {
    FMT_RGB  = 2'd0,
    FMT_ARGB = 2'd1,
    FMT_GRAY = 2'd2
  } src_fmt_e;

  // output kinds
  typedef enum logic [1:0] {
    MODE_GRAY  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_DEEP  = 2'd2
  } out_mode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_OUTPUT_MODE   = 2'd1,
    REG_CHECKER_DARK  = 2'd2,
    REG_CHECKER_LIGHT = 2'd3
  } cfg_reg_e;

  // captured input pixel
  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] luma;
    logic             cell_odd;
  } pix_t;

  // intermediate values after the first compute stage
  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] level;
    logic [PIX_W-1:0] avg;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] ch_red;
    logic [PIX_W-1:0] ch_green;
    logic [PIX_W-1:0] ch_blue;
  } mid_t;

  // result beat
  typedef struct packed {
    logic [PIX_W-1:0] gray_level;
    logic [IDX_W-1:0] color_index;
    logic [PIX_W-1:0] deep_red;
    logic [PIX_W-1:0] deep_green;
    logic [PIX_W-1:0] deep_blue;
  } res_t;

  // pipeline occupancy, handed to the checks
  typedef struct packed {
    logic in_full;
    logic mid_full;
    logic out_full;
  } pipe_stat_t;

endpackage

/* rtl/ppca_if.sv */
// valid/ready channel interfaces for pixels in, results out and register writes
// depends on ppca_pkg for field widths
interface ppca_pix_in_if import ppca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] alpha;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] luma_in;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;

  modport source (output valid, alpha, red, green, blue, luma_in, out_row, out_col,
                  input ready);
  modport sink   (input valid, alpha, red, green, blue, luma_in, out_row, out_col,
                  output ready);
endinterface

interface ppca_pix_out_if import ppca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gray_level;
  logic [IDX_W-1:0] color_index;
  logic [PIX_W-1:0] deep_red;
  logic [PIX_W-1:0] deep_green;
  logic [PIX_W-1:0] deep_blue;

  modport source (output valid, gray_level, color_index, deep_red, deep_green, deep_blue,
                  input ready);
  modport sink   (input valid, gray_level, color_index, deep_red, deep_green, deep_blue,
                  output ready);
endinterface

interface ppca_cfg_if import ppca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ppca_blend.sv */
// alpha blend product sum: (255 - a) * x + a * t, full 16-bit result
// depends on ppca_pkg for widths and the alpha full-scale constant
module ppca_blend import ppca_pkg::*; (
  input  logic [PIX_W-1:0]  x_i,
  input  logic [PIX_W-1:0]  alpha_i,
  input  logic [PIX_W-1:0]  level_i,
  output logic [PROD_W-1:0] sum_o
);

  logic [PIX_W-1:0]  inv_alpha;
  logic [PROD_W-1:0] prod_src;
  logic [PROD_W-1:0] prod_lvl;

  // two 8x8 products; the sum never exceeds 255 * 255
  assign inv_alpha = ALPHA_MAX - alpha_i;
  assign prod_src  = PROD_W'(inv_alpha) * PROD_W'(x_i);
  assign prod_lvl  = PROD_W'(alpha_i) * PROD_W'(level_i);
  assign sum_o     = prod_src + prod_lvl;

endmodule

/* rtl/preview_pixel_convert_alpha_checker.sv */
// top level: preview pixel converter with alpha blend over a checkerboard
// depends on ppca_pkg, the channel interfaces, ppca_blend and assert_macros.svh
// a result is valid after its beat passes the input, mid and result registers
// throughput: one pixel per clock while the output is not stalled
// the rate is set by the three-register pipeline; stalls back up stage by stage
// reset: pipeline empty, source_format RGB, output_mode gray, levels 0xA0 / 0xE0
`include "assert_macros.svh"

module preview_pixel_convert_alpha_checker import ppca_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ppca_cfg_if.sink               cfg_i,
  ppca_pix_in_if.sink            pix_i,
  ppca_pix_out_if.source         pix_o
);

  // configuration registers
  logic [1:0]       src_fmt_q;
  logic [1:0]       out_mode_q;
  logic [PIX_W-1:0] checker_dark_q;
  logic [PIX_W-1:0] checker_light_q;

  // pipeline registers
  logic       in_valid_q, mid_valid_q, out_valid_q;
  pix_t       in_q;
  mid_t       mid_d, mid_q;
  res_t       res_d, res_q;
  pipe_stat_t stat;

  logic out_en, mid_en, in_en;

  // stage one signals
  logic [SUM3_W-1:0]          sum3;
  logic [SUM3_W+SUM3_W-1:0]   sum3_scaled;
  logic [PIX_W-1:0]           cell_level;
  logic [PROD_W-1:0]          blend_red, blend_green, blend_blue;

  // stage two signals
  logic [PROD_W-1:0] blend_gray;
  logic [PROD_W-1:0] gray_div;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q       <= FMT_RGB;
      out_mode_q      <= MODE_GRAY;
      checker_dark_q  <= CHECKER_DARK_RST;
      checker_light_q <= CHECKER_LIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SOURCE_FORMAT: src_fmt_q       <= cfg_i.data[1:0];
        REG_OUTPUT_MODE:   out_mode_q      <= cfg_i.data[1:0];
        REG_CHECKER_DARK:  checker_dark_q  <= cfg_i.data;
        REG_CHECKER_LIGHT: checker_light_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // stall chain: a stage moves when it is empty or the next one moves
  assign out_en      = !out_valid_q || pix_o.ready;
  assign mid_en      = !mid_valid_q || out_en;
  assign in_en       = !in_valid_q || mid_en;
  assign pix_i.ready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en)  in_valid_q  <= pix_i.valid;
      if (mid_en) mid_valid_q <= in_valid_q;
      if (out_en) out_valid_q <= mid_valid_q;
    end
  end

  // input register; the checker cell parity is bit 3 of row xor bit 3 of column
  always_ff @(posedge clk_i) begin
    if (in_en && pix_i.valid) begin
      in_q.alpha    <= pix_i.alpha;
      in_q.red      <= pix_i.red;
      in_q.green    <= pix_i.green;
      in_q.blue     <= pix_i.blue;
      in_q.luma     <= pix_i.luma_in;
      in_q.cell_odd <= pix_i.out_row[3] ^ pix_i.out_col[3];
    end
  end

  // stage one: channel average, checker level, per-channel blends
  assign sum3        = SUM3_W'(in_q.red) + SUM3_W'(in_q.green) + SUM3_W'(in_q.blue);
  assign sum3_scaled = (2*SUM3_W)'(sum3) * (2*SUM3_W)'(DIV3_MUL);
  assign cell_level  = in_q.cell_odd ? checker_light_q : checker_dark_q;

  ppca_blend u_blend_red (
    .x_i     (in_q.red),
    .alpha_i (in_q.alpha),
    .level_i (cell_level),
    .sum_o   (blend_red)
  );

  ppca_blend u_blend_green (
    .x_i     (in_q.green),
    .alpha_i (in_q.alpha),
    .level_i (cell_level),
    .sum_o   (blend_green)
  );

  ppca_blend u_blend_blue (
    .x_i     (in_q.blue),
    .alpha_i (in_q.alpha),
    .level_i (cell_level),
    .sum_o   (blend_blue)
  );

  always_comb begin
    mid_d.alpha = in_q.alpha;
    mid_d.level = cell_level;
    mid_d.avg   = sum3_scaled[DIV3_SHIFT +: PIX_W];
    mid_d.luma  = in_q.luma;
    // argb channels are blended with a plain shift, others pass through
    if (src_fmt_q == FMT_ARGB) begin
      mid_d.ch_red   = blend_red[PIX_W +: PIX_W];
      mid_d.ch_green = blend_green[PIX_W +: PIX_W];
      mid_d.ch_blue  = blend_blue[PIX_W +: PIX_W];
    end else begin
      mid_d.ch_red   = in_q.red;
      mid_d.ch_green = in_q.green;
      mid_d.ch_blue  = in_q.blue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_en && in_valid_q) begin
      mid_q <= mid_d;
    end
  end

  // stage two: gray blend of the average, exact divide by 255
  ppca_blend u_blend_gray (
    .x_i     (mid_q.avg),
    .alpha_i (mid_q.alpha),
    .level_i (mid_q.level),
    .sum_o   (blend_gray)
  );

  // x / 255 == (x + (x >> 8) + 1) >> 8 for all 16-bit x in range
  assign gray_div = blend_gray + PROD_W'(blend_gray[PROD_W-1:PIX_W]) + PROD_W'(1);

  // result selection; fields the mode does not use stay zero
  always_comb begin
    res_d = '0;
    case (out_mode_e'(out_mode_q))
      MODE_GRAY: begin
        case (src_fmt_e'(src_fmt_q))
          FMT_RGB:  res_d.gray_level = mid_q.avg;
          FMT_ARGB: res_d.gray_level = gray_div[PIX_W +: PIX_W];
          FMT_GRAY: res_d.gray_level = mid_q.luma;
          default: ;
        endcase
      end
      MODE_COLOR: begin
        case (src_fmt_e'(src_fmt_q))
          FMT_RGB, FMT_ARGB: begin
            res_d.color_index = {mid_q.ch_red[7:4], mid_q.ch_green[7:4], mid_q.ch_blue[7:4]};
          end
          FMT_GRAY: begin
            res_d.color_index = {mid_q.luma[7:4], mid_q.luma[7:4], mid_q.luma[7:4]};
          end
          default: ;
        endcase
      end
      MODE_DEEP: begin
        case (src_fmt_e'(src_fmt_q))
          FMT_RGB, FMT_ARGB: begin
            res_d.deep_red   = mid_q.ch_red;
            res_d.deep_green = mid_q.ch_green;
            res_d.deep_blue  = mid_q.ch_blue;
          end
          FMT_GRAY: res_d.gray_level = mid_q.luma;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_en && mid_valid_q) begin
      res_q <= res_d;
    end
  end

  // output port
  assign pix_o.valid       = out_valid_q;
  assign pix_o.gray_level  = res_q.gray_level;
  assign pix_o.color_index = res_q.color_index;
  assign pix_o.deep_red    = res_q.deep_red;
  assign pix_o.deep_green  = res_q.deep_green;
  assign pix_o.deep_blue   = res_q.deep_blue;

  // occupancy summary for the checks
  assign stat.in_full  = in_valid_q;
  assign stat.mid_full = mid_valid_q;
  assign stat.out_full = out_valid_q;

  // checks
  `PPCA_ASSERT_IMP(a_full_stalls_input, clk_i, rst_ni,
    stat.in_full && stat.mid_full && stat.out_full && !pix_o.ready, !pix_i.ready)
  `PPCA_ASSERT_NEXT(a_mid_advances, clk_i, rst_ni, stat.mid_full && out_en, stat.out_full)
  `PPCA_ASSERT_IMP(a_index_excludes_others, clk_i, rst_ni,
    pix_o.valid && pix_o.color_index != '0,
    pix_o.gray_level == '0 && pix_o.deep_red == '0 && pix_o.deep_green == '0 &&
    pix_o.deep_blue == '0)
  `PPCA_ASSERT_IMP(a_deep_excludes_gray, clk_i, rst_ni,
    pix_o.valid && (pix_o.deep_red != '0 || pix_o.deep_green != '0 || pix_o.deep_blue != '0),
    pix_o.gray_level == '0)

endmodule
